// ===== hdl/d2q9_moments_and_equilibrium_assert.svh =====
// assertion macros for the d2q9 moments and equilibrium block
// used by the queue and the back-end pipeline; no other dependencies
`ifndef D2Q9_MOMENTS_AND_EQUILIBRIUM_ASSERT_SVH
`define D2Q9_MOMENTS_AND_EQUILIBRIUM_ASSERT_SVH
`ifndef SYNTHESIS
`define D2Q_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("d2q assertion failed");
`define D2Q_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  `D2Q_ASSERT(lbl, clk, rst, (pre) |=> (post))
`else
`define D2Q_ASSERT(lbl, clk, rst, prop)
`define D2Q_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== hdl/d2q_pkg.sv =====
// shared types, constants and the divider step for the d2q9 block
// no dependencies
`timescale 1ns / 1ps
package d2q_pkg;

  // moments handed from the front end to the back end
  typedef struct packed {
    logic signed [35:0] rho;
    logic signed [34:0] jx;
    logic signed [34:0] jy;
  } mom_t;

  // one velocity divider lane
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [34:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } lane_t;

  // queue sizing
  localparam int QDEPTH = 2;
  localparam int QPTRW  = 1;
  localparam int QCNTW  = 2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // weight selection per direction: rest uses 4/9, diagonals use 1/36
  localparam logic [8:0] W_NUM4  = 9'b0_0000_0001;
  localparam logic [8:0] W_DEN36 = 9'b1_1110_0000;

  // ceil(2^40 / 9), exact floor(n/9) for n below 2^36
  localparam logic [36:0] DIV9_M = 37'd122167958642;

  // one restoring division step
  function automatic lane_t div_step(lane_t a, logic [34:0] d);
    logic [35:0] r2;
    lane_t       o;
    r2 = {a.rem, a.low[31]};
    o  = a;
    if (r2 >= {1'b0, d}) begin
      o.rem = 35'(r2 - {1'b0, d});
      o.quo = {a.quo[30:0], 1'b1};
    end else begin
      o.rem = r2[34:0];
      o.quo = {a.quo[30:0], 1'b0};
    end
    o.low = {a.low[30:0], 1'b0};
    return o;
  endfunction

  // signed saturated velocity from a finished lane
  function automatic logic signed [31:0] vel_sat(lane_t a);
    logic signed [31:0] v;
    if (a.ovf) begin
      v = a.neg ? S32_MIN : S32_MAX;
    end else if (a.neg) begin
      v = (a.quo > 32'h8000_0000) ? S32_MIN : $signed(32'(-a.quo));
    end else begin
      v = a.quo[31] ? S32_MAX : $signed(a.quo);
    end
    return v;
  endfunction

endpackage

// ===== hdl/d2q_front.sv =====
// front end: accepts one node of populations and forms density and momentum
// depends on d2q_pkg
`timescale 1ns / 1ps
module d2q_front import d2q_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // pop_rest, pop_east, pop_north, pop_west, pop_south,
                                  // pop_ne, pop_nw, pop_sw, pop_se, 32 bits each
  output logic         push,
  output mom_t         push_data,
  input  logic         full
);

  logic               fv;
  mom_t               mom;
  logic signed [31:0] f [9];

  // unpack populations
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      f[i] = $signed(s_tdata[32*i +: 32]);
    end
  end

  assign s_tready  = !fv || !full;
  assign push      = fv;
  assign push_data = mom;

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  // moments
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mom.rho <= 36'(f[0]) + 36'(f[1]) + 36'(f[2]) + 36'(f[3]) + 36'(f[4])
               + 36'(f[5]) + 36'(f[6]) + 36'(f[7]) + 36'(f[8]);
      mom.jx  <= 35'(f[1]) + 35'(f[5]) + 35'(f[8]) - 35'(f[3]) - 35'(f[6]) - 35'(f[7]);
      mom.jy  <= 35'(f[2]) + 35'(f[5]) + 35'(f[6]) - 35'(f[4]) - 35'(f[7]) - 35'(f[8]);
    end
  end

endmodule

// ===== hdl/d2q_queue.sv =====
// two-entry queue that decouples the front end from the back end
// depends on d2q_pkg and the assertion header
`timescale 1ns / 1ps
`include "d2q9_moments_and_equilibrium_assert.svh"
module d2q_queue import d2q_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mom_t push_data,
  output logic full,
  output logic pop_valid,
  output mom_t pop_data,
  input  logic pop
);

  mom_t             mem [QDEPTH];
  logic [QPTRW-1:0] wr_ptr;
  logic [QPTRW-1:0] rd_ptr;
  logic [QCNTW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == QCNTW'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `D2Q_ASSERT(a_cnt_range, clk, rst, count <= QCNTW'(QDEPTH))
  `D2Q_ASSERT_NEXT(a_cnt_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `D2Q_ASSERT_NEXT(a_cnt_dn, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

// ===== hdl/d2q_back.sv =====
// back end: velocity divider, squares, brackets, products and weighting
// depends on d2q_pkg and the assertion header
`timescale 1ns / 1ps
`include "d2q9_moments_and_equilibrium_assert.svh"
module d2q_back import d2q_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  mom_t                pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [35:0]  density,
  output logic signed [31:0]  vel_x,
  output logic signed [31:0]  vel_y,
  output logic [8:0][31:0]    eq
);

  localparam int NDIV = 32;
  localparam logic signed [63:0]  ONE    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [100:0] P_HI   = 101'sd137438953472;
  localparam logic signed [100:0] P_LO   = -P_HI;
  localparam logic signed [40:0]  LIM9   = 41'sd19327352832;
  localparam logic signed [40:0]  LIM36  = 41'sd77309411328;
  localparam logic [17:0]         M_HI   = DIV9_M[36:19];
  localparam logic [18:0]         M_LO   = DIV9_M[18:0];

  typedef struct packed {
    logic signed [35:0] rho;
    logic               pos;
  } side0_t;

  typedef struct packed {
    logic signed [35:0] rho;
    logic               pos;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } side_t;

  logic en;

  // divider pipeline, index 0 is the entry stage
  lane_t  dx [NDIV+1];
  lane_t  dy [NDIV+1];
  side0_t sd [NDIV+1];
  logic   vd [NDIV+1];

  side_t sv, sa, sb, sc1, sc2, sc3, sd1, sd2;
  logic  vv, va, vb, vc1, vc2, vc3, vd1, vd2;

  logic signed [63:0]  ux2, uy2, epp2, epm2;
  logic signed [63:0]  br   [9];
  logic signed [68:0]  plo  [9];
  logic signed [67:0]  phi  [9];
  logic signed [100:0] psum [9];
  logic [35:0]         nd   [9];
  logic [53:0]         mh   [9];
  logic [54:0]         ml   [9];

  assign en        = !vd2 || out_ready;
  assign pop       = pop_valid && en;
  assign out_valid = vd2;

  // entry: magnitudes, first remainder and overflow test
  lane_t lx_in, ly_in;
  always_comb begin
    logic [33:0]             magx, magy;
    logic [34+FRAC_BITS-1:0] shx, shy;
    magx = pop_data.jx[34] ? 34'(-pop_data.jx) : pop_data.jx[33:0];
    magy = pop_data.jy[34] ? 34'(-pop_data.jy) : pop_data.jy[33:0];
    shx  = {magx, {FRAC_BITS{1'b0}}};
    shy  = {magy, {FRAC_BITS{1'b0}}};
    lx_in.neg = pop_data.jx[34];
    ly_in.neg = pop_data.jy[34];
    lx_in.rem = 35'(shx >> 32);
    ly_in.rem = 35'(shy >> 32);
    lx_in.low = shx[31:0];
    ly_in.low = shy[31:0];
    lx_in.quo = '0;
    ly_in.quo = '0;
    lx_in.ovf = (35'(shx >> 32) >= pop_data.rho[34:0]);
    ly_in.ovf = (35'(shy >> 32) >= pop_data.rho[34:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0]     <= lx_in;
      dy[0]     <= ly_in;
      sd[0].rho <= pop_data.rho;
      sd[0].pos <= !pop_data.rho[35] && (pop_data.rho != '0);
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else if (en) begin
        vd[k+1] <= vd[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dx[k+1] <= div_step(dx[k], sd[k].rho[34:0]);
        dy[k+1] <= div_step(dy[k], sd[k].rho[34:0]);
        sd[k+1] <= sd[k];
      end
    end
  end

  // valid chain of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vv  <= 1'b0;
      va  <= 1'b0;
      vb  <= 1'b0;
      vc1 <= 1'b0;
      vc2 <= 1'b0;
      vc3 <= 1'b0;
      vd1 <= 1'b0;
      vd2 <= 1'b0;
    end else if (en) begin
      vv  <= vd[NDIV];
      va  <= vv;
      vb  <= va;
      vc1 <= vb;
      vc2 <= vc1;
      vc3 <= vc2;
      vd1 <= vc3;
      vd2 <= vd1;
    end
  end

  // squares of the velocity terms
  always_comb begin
    logic signed [63:0] px, py;
    logic signed [32:0] spp, spm;
    logic signed [65:0] qpp, qpm;
    px   = sv.ux * sv.ux;
    py   = sv.uy * sv.uy;
    spp  = sv.ux + sv.uy;
    spm  = sv.ux - sv.uy;
    qpp  = spp * spp;
    qpm  = spm * spm;
    ux2  = px >>> FRAC_BITS;
    uy2  = py >>> FRAC_BITS;
    epp2 = 64'(qpp >>> FRAC_BITS);
    epm2 = 64'(qpm >>> FRAC_BITS);
  end

  // brackets, one per direction; -ux-uy reaches +2^32, so eu carries 34 bits
  logic signed [63:0] a_ux2, a_uy2, a_epp2, a_epm2;
  logic signed [63:0] br_n [9];
  always_comb begin
    logic signed [33:0] eu  [9];
    logic signed [63:0] eu2 [9];
    logic signed [63:0] usq;
    eu[0] = '0;          eu2[0] = '0;
    eu[1] = sa.ux;       eu2[1] = a_ux2;
    eu[2] = sa.uy;       eu2[2] = a_uy2;
    eu[3] = -sa.ux;      eu2[3] = a_ux2;
    eu[4] = -sa.uy;      eu2[4] = a_uy2;
    eu[5] = sa.ux + sa.uy;  eu2[5] = a_epp2;
    eu[6] = sa.uy - sa.ux;  eu2[6] = a_epm2;
    eu[7] = -sa.ux - sa.uy; eu2[7] = a_epp2;
    eu[8] = sa.ux - sa.uy;  eu2[8] = a_epm2;
    usq = a_ux2 + a_uy2;
    for (int i = 0; i < 9; i++) begin
      br_n[i] = ONE + 64'(eu[i]) * 64'sd3 + ((eu2[i] * 64'sd9) >>> 1)
              - ((usq * 64'sd3) >>> 1);
    end
  end

  // density times bracket, finished product and divide-by-nine operand
  logic [35:0] nd_n [9];
  always_comb begin
    logic signed [100:0] pf;
    logic signed [38:0]  p;
    logic signed [40:0]  v, lim, n;
    for (int i = 0; i < 9; i++) begin
      pf = psum[i] >>> FRAC_BITS;
      if (pf > P_HI) begin
        p = 39'(P_HI);
      end else if (pf < P_LO) begin
        p = 39'(P_LO);
      end else begin
        p = 39'(pf);
      end
      v   = W_NUM4[i] ? (41'(p) <<< 2) : 41'(p);
      lim = W_DEN36[i] ? LIM36 : LIM9;
      if (v > lim) begin
        v = lim;
      end else if (v < -lim) begin
        v = -lim;
      end
      n       = v + lim;
      nd_n[i] = W_DEN36[i] ? n[37:2] : n[35:0];
    end
  end

  // final quotient, offset removal and saturation
  logic [8:0][31:0] eq_n;
  always_comb begin
    logic [72:0]        t;
    logic signed [33:0] r;
    for (int i = 0; i < 9; i++) begin
      t = {mh[i], 19'b0} + 73'(ml[i]);
      r = $signed({1'b0, t[72:40]}) - 34'sd2147483648;
      if (!sd1.pos) begin
        eq_n[i] = '0;
      end else if (r > 34'(S32_MAX)) begin
        eq_n[i] = S32_MAX;
      end else begin
        eq_n[i] = r[31:0];
      end
    end
  end

  // arithmetic stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      sv.rho <= sd[NDIV].rho;
      sv.pos <= sd[NDIV].pos;
      sv.ux  <= sd[NDIV].pos ? vel_sat(dx[NDIV]) : '0;
      sv.uy  <= sd[NDIV].pos ? vel_sat(dy[NDIV]) : '0;
      sa     <= sv;
      a_ux2  <= ux2;
      a_uy2  <= uy2;
      a_epp2 <= epp2;
      a_epm2 <= epm2;
      sb     <= sa;
      sc1    <= sb;
      sc2    <= sc1;
      sc3    <= sc2;
      sd1    <= sc3;
      sd2    <= sd1;
      for (int i = 0; i < 9; i++) begin
        br[i]   <= br_n[i];
        plo[i]  <= sb.rho * $signed({1'b0, br[i][31:0]});
        phi[i]  <= sb.rho * $signed(br[i][63:32]);
        psum[i] <= (101'(phi[i]) <<< 32) + 101'(plo[i]);
        nd[i]   <= nd_n[i];
        mh[i]   <= nd[i] * M_HI;
        ml[i]   <= nd[i] * M_LO;
      end
      eq <= eq_n;
    end
  end

  assign density = sd2.rho;
  assign vel_x   = sd2.ux;
  assign vel_y   = sd2.uy;

  `D2Q_ASSERT_NEXT(a_stall_hold, clk, rst, vd2 && !out_ready, vd2)
  `D2Q_ASSERT(a_zero_vel, clk, rst, (vd2 && !sd2.pos) |-> (sd2.ux == '0 && eq[0] == '0))
  `D2Q_ASSERT(a_pos_rho, clk, rst, (vd2 && sd2.pos) |-> (sd2.rho > 36'sd0))

endmodule

// ===== hdl/d2q9_moments_and_equilibrium.sv =====
// D2Q9 node moments and BGK equilibrium, top level
// Input channel s_*: one node per transfer, nine signed populations in s_tdata.
// Output channel m_*: density, velocity and the nine equilibria in m_tdata.
// A front stage forms density and momentum and pushes them into a two-entry
// queue; the back pipeline takes one node per cycle from the queue.
// Pipeline order: the front register loads on the input transfer edge, then 1 queue,
// 1 divider entry, 32 divider stages (one quotient bit per stage for both velocity
// components) and 8 arithmetic stages, the last of which drives m_tvalid.
// The block accepts one node per cycle while the receiver does not stall it.
// A stalled receiver freezes the back pipeline; the queue and front register
// then absorb up to three more nodes before s_tready drops.
// Reset clears all valid flags and the queue; no results are pending after it.
// Depends on d2q_pkg, d2q_front, d2q_queue and d2q_back.
`timescale 1ns / 1ps
module d2q9_moments_and_equilibrium import d2q_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // pop_rest, pop_east, pop_north, pop_west, pop_south,
                                  // pop_ne, pop_nw, pop_sw, pop_se (32 bits each)
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [391:0] m_tdata    // node_density (36), vel_x, vel_y, eq_rest, eq_east,
                                  // eq_north, eq_west, eq_south, eq_ne, eq_nw, eq_sw,
                                  // eq_se (32 each), 4 zero bits
);

  logic               push, full, pop_valid, pop;
  mom_t               push_data, pop_data;
  logic signed [35:0] density;
  logic signed [31:0] vel_x, vel_y;
  logic [8:0][31:0]   eq;

  d2q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  d2q_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop)
  );

  d2q_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .density   (density),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .eq        (eq)
  );

  // pack the result
  assign m_tdata = {4'b0, eq, vel_y, vel_x, density};

endmodule

// ===== tb/d2q9_moments_and_equilibrium_tb.sv =====
// testbench for d2q9_moments_and_equilibrium: directed table then random nodes
// depends on the block under test only; results checked against a local predictor
`timescale 1ns / 1ps
module d2q9_moments_and_equilibrium_tb;

  localparam int FRAC       = 28;
  localparam int NUM_RANDOM = 1750;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN      = 60;

  typedef struct packed {
    logic [35:0]       rho;
    logic [10:0][31:0] fld;   // vel_x, vel_y, then eq_rest .. eq_se
  } node_res_t;

  typedef struct {
    logic [31:0] pop[9];
    bit          typed;       // expectation typed in: zero velocity and equilibria
    logic [35:0] rho;
  } table_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [391:0] m_tdata;

  node_res_t expected_nodes[$];
  int        mismatches;
  int        cycles;
  bit        in_done;

  const int dir_x[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  const int dir_y[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  const string fld_name[11] = '{"vel_x", "vel_y", "eq_rest", "eq_east", "eq_north",
    "eq_west", "eq_south", "eq_ne", "eq_nw", "eq_sw", "eq_se"};

  d2q9_moments_and_equilibrium u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b / 2^FRAC), saturated to 64 bits
  function automatic longint mul_frac(longint a, longint b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p  = (wa * wb) >>> FRAC;
    if (p[127:63] != {65{p[127]}}) return p[127] ? 64'sh8000_0000_0000_0000
                                                 : 64'sh7fff_ffff_ffff_ffff;
    return p[63:0];
  endfunction

  // momentum over density, truncated, saturated to 32 bits
  function automatic logic [31:0] velocity_of(longint j, longint rho);
    logic [63:0] mj, q;
    mj = (j < 0) ? -j : j;
    q  = (mj << FRAC) / 64'(rho);
    if (j < 0) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
  endfunction

  function automatic node_res_t predict_node(logic [31:0] pop[9]);
    node_res_t r;
    longint f, rho, jx, jy, ux, uy, usq, eu, eu2, br, p, n, q, num, den;
    rho = 0; jx = 0; jy = 0;
    for (int i = 0; i < 9; i++) begin
      f   = longint'($signed(pop[i]));
      rho += f;
      jx  += dir_x[i] * f;
      jy  += dir_y[i] * f;
    end
    r     = '0;
    r.rho = rho[35:0];
    if (rho <= 0) return r;
    r.fld[0] = velocity_of(jx, rho);
    r.fld[1] = velocity_of(jy, rho);
    ux  = longint'($signed(r.fld[0]));
    uy  = longint'($signed(r.fld[1]));
    usq = mul_frac(ux, ux) + mul_frac(uy, uy);
    for (int i = 0; i < 9; i++) begin
      eu  = dir_x[i] * ux + dir_y[i] * uy;
      eu2 = mul_frac(eu, eu);
      br  = (64'sd1 <<< FRAC) + 3 * eu + ((9 * eu2) >>> 1) - ((3 * usq) >>> 1);
      p   = mul_frac(rho, br);
      if (p > (64'sd1 <<< 40)) p = 64'sd1 <<< 40;
      if (p < -(64'sd1 <<< 40)) p = -(64'sd1 <<< 40);
      num = (i == 0) ? 4 : 1;
      den = (i < 5) ? 9 : 36;
      n   = p * num;
      q   = n / den;
      if ((n % den) != 0 && n < 0) q--;
      if (q > 64'sh7fff_ffff) q = 64'sh7fff_ffff;
      if (q < -64'sh8000_0000) q = -64'sh8000_0000;
      r.fld[2 + i] = q[31:0];
    end
    return r;
  endfunction

  // one node transfer, waits for acceptance; leaves tvalid high
  task automatic send_node(logic [31:0] pop[9], bit typed, logic [35:0] rho);
    node_res_t e;
    bit        ok;
    s_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) s_tdata[32*i +: 32] <= pop[i];
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    if (typed) begin
      e     = '0;
      e.rho = rho;
    end else begin
      e = predict_node(pop);
    end
    expected_nodes.push_back(e);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random node: mostly near-equilibrium populations, some raw or extreme
  task automatic random_node(output logic [31:0] pop[9]);
    int  mode, base;
    mode = $urandom_range(0, 9);
    base = $urandom_range(1 << 25, 3 << 28);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0, 1: pop[i] = $urandom;
        2: pop[i] = (i == 0) ? 32'($urandom_range(0, 1 << 20))
                             : 32'($urandom_range(0, 1 << 31)) - 32'h4000_0000;
        default: pop[i] = 32'(base >> ((i == 0) ? 1 : (i < 5) ? 3 : 5))
                          + 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      endcase
    end
  endtask

  // stimulus
  initial begin
    table_row_t  rows[$];
    table_row_t  row;
    logic [31:0] pop[9];
    int          burst;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    in_done  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all zero: density zero, everything zero
    row = '{pop: '{default: 32'h0}, typed: 1'b1, rho: 36'h0};
    rows.push_back(row);
    // all minimum: density -9 * 2^31
    row = '{pop: '{default: 32'h8000_0000}, typed: 1'b1, rho: 36'hb_8000_0000};
    rows.push_back(row);
    // negative density from one population
    row = '{pop: '{default: 32'h0}, typed: 1'b1, rho: 36'hf_ffff_ffff};
    row.pop[3] = 32'hffff_ffff;
    rows.push_back(row);
    // all maximum
    row = '{pop: '{default: 32'h7fff_ffff}, typed: 1'b0, rho: '0};
    rows.push_back(row);
    // each direction alone at 1.0
    for (int d = 0; d < 9; d++) begin
      row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
      row.pop[d] = 32'h1000_0000;
      rows.push_back(row);
    end
    // tiny density with large momentum: velocity and equilibria saturate
    row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
    row.pop[1] = 32'h4000_0000; row.pop[3] = 32'hc000_0001;
    rows.push_back(row);
    row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
    row.pop[2] = 32'hc000_0001; row.pop[4] = 32'h4000_0000;
    rows.push_back(row);
    row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
    row.pop[5] = 32'h7fff_ffff; row.pop[7] = 32'h8000_0001; row.pop[0] = 32'h1;
    rows.push_back(row);
    row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
    row.pop[6] = 32'h7fff_ffff; row.pop[8] = 32'h7fff_ffff; row.pop[1] = 32'h8000_0000;
    rows.push_back(row);
    // both velocities at the negative limit
    row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
    row.pop[7] = 32'h4000_0000; row.pop[0] = 32'hc000_0001;
    rows.push_back(row);
    // density of one lsb
    row = '{pop: '{default: 32'h0}, typed: 1'b0, rho: '0};
    row.pop[0] = 32'h1;
    rows.push_back(row);
    // resting fluid at unit density
    row = '{pop: '{32'h071c_71c7, 32'h01c7_1c72, 32'h01c7_1c72, 32'h01c7_1c72,
                   32'h01c7_1c72, 32'h0071_c71c, 32'h0071_c71c, 32'h0071_c71c,
                   32'h0071_c71c}, typed: 1'b0, rho: '0};
    rows.push_back(row);

    foreach (rows[k]) send_node(rows[k].pop, rows[k].typed, rows[k].rho);

    // random part in bursts
    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        // hold off until the pipeline is empty
        s_tvalid <= 1'b0;
        while (expected_nodes.size() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      end
      burst--;
      random_node(pop);
      send_node(pop, 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    in_done = 1'b1;
  end

  // receiver stall pattern, stepping through four modes by cycle count
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case ((cycles / 200) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= (cycles % 7) < 3;
        default: m_tready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  // result check; a transfer seen at the falling edge completes on the next rising one
  always @(negedge clk) begin
    node_res_t e, a;
    if (!rst && m_tvalid && m_tready) begin
      a.rho = m_tdata[35:0];
      for (int k = 0; k < 11; k++) a.fld[k] = m_tdata[36 + 32*k +: 32];
      if (expected_nodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
      end else begin
        e = expected_nodes.pop_front();
        if (e.rho !== a.rho) begin
          mismatches++;
          if (mismatches <= 10)
            $display("node_density: expected %h, got %h", e.rho, a.rho);
        end
        for (int k = 0; k < 11; k++) begin
          if (e.fld[k] !== a.fld[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s: expected %h, got %h", fld_name[k], e.fld[k], a.fld[k]);
          end
        end
      end
    end
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // end of run
  initial begin
    mismatches = 0;
    cycles     = 0;
    wait (in_done);
    while (expected_nodes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && expected_nodes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/d2q_pkg.sv
hdl/d2q_front.sv
hdl/d2q_queue.sv
hdl/d2q_back.sv
hdl/d2q9_moments_and_equilibrium.sv
tb/d2q9_moments_and_equilibrium_tb.sv
